// ===== sv/qte_pkg.sv =====
// Shared constants, widths and the CORDIC angle table of the quaternion to Euler angle core.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package qte_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF     = 16;

    // Components wider than this are floored down to it before the products.
    localparam int WORK_BITS  = 24;
    localparam int PROD_W     = 2 * WORK_BITS;
    localparam int SUM_W      = PROD_W + 2;
    // Pitch operands after the scale-down: q below 2^32, p clamped to [-q, q].
    localparam int PQ_W       = 32;
    localparam int PP_W       = PQ_W + 1;
    localparam int T_W        = 5;
    localparam int RAD_W      = 2 * PQ_W;
    localparam int SQ_STAGES  = PQ_W;

    // Angle engine widths: magnitude, normalized operands, rotation datapath.
    localparam int MAG_W      = SUM_W;
    localparam int NORM_W     = MAG_W + 1;
    localparam int CRD_W      = NORM_W + 3;
    localparam int NORM_STEPS = 6;
    localparam int CRD_STAGES = 31;
    localparam int ACC_W      = 32;

    // Pipeline depths in register stages.
    localparam int RY_LAT     = 2;
    localparam int PREP_LAT   = 6;
    localparam int CORDIC_LAT = 1 + NORM_STEPS + 1 + CRD_STAGES;

    localparam logic [ACC_W-1:0] ANG_ZERO     = 32'h0000_0000;
    localparam logic [ACC_W-1:0] ANG_HALF_PI  = 32'h4000_0000;
    localparam logic [ACC_W-1:0] ANG_NHALF_PI = 32'hC000_0000;
    localparam logic [ACC_W-1:0] ANG_PI       = 32'h8000_0000;

    // round(atan(2^-i) * 2^31 / pi)
    function automatic logic [ACC_W-1:0] f_atan(input int i);
        logic [ACC_W-1:0] a;
        case (i)
            0:  a = 32'd536870912;
            1:  a = 32'd316933406;
            2:  a = 32'd167458907;
            3:  a = 32'd85004756;
            4:  a = 32'd42667331;
            5:  a = 32'd21354465;
            6:  a = 32'd10679838;
            7:  a = 32'd5340245;
            8:  a = 32'd2670163;
            9:  a = 32'd1335087;
            10: a = 32'd667544;
            11: a = 32'd333772;
            12: a = 32'd166886;
            13: a = 32'd83443;
            14: a = 32'd41722;
            15: a = 32'd20861;
            16: a = 32'd10430;
            17: a = 32'd5215;
            18: a = 32'd2608;
            19: a = 32'd1304;
            20: a = 32'd652;
            21: a = 32'd326;
            22: a = 32'd163;
            23: a = 32'd81;
            24: a = 32'd41;
            25: a = 32'd20;
            26: a = 32'd10;
            27: a = 32'd5;
            28: a = 32'd3;
            29: a = 32'd1;
            30: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== sv/qte_if.sv =====
// Valid/ready channel interfaces of the quaternion to Euler angle core.
// Depends on qte_pkg for default widths.
`default_nettype none

interface qte_quat_if
    import qte_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) ();
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] quat_w;
    logic signed [COMPONENT_BITS-1:0] quat_x;
    logic signed [COMPONENT_BITS-1:0] quat_y;
    logic signed [COMPONENT_BITS-1:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if
    import qte_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

`default_nettype wire

// ===== sv/qte_prep.sv =====
// Front end: component products, angle operands, and the pitch radicand q^2 - p^2.
// Depends on qte_pkg.
`default_nettype none

module qte_prep
    import qte_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic signed [COMPONENT_BITS-1:0] i_w,
    input  wire logic signed [COMPONENT_BITS-1:0] i_x,
    input  wire logic signed [COMPONENT_BITS-1:0] i_y,
    input  wire logic signed [COMPONENT_BITS-1:0] i_z,
    output logic signed [SUM_W-1:0]               o_roll_s,
    output logic signed [SUM_W-1:0]               o_roll_c,
    output logic signed [SUM_W-1:0]               o_yaw_s,
    output logic signed [SUM_W-1:0]               o_yaw_c,
    output logic [RAD_W-1:0]                      o_v,
    output logic signed [PP_W-1:0]                o_p
);

    logic signed [WORK_BITS-1:0] w_w, w_x, w_y, w_z;

    // Wide components are floored to the working width by keeping their top bits.
    if (COMPONENT_BITS > WORK_BITS) begin : g_shr
        localparam int SH = COMPONENT_BITS - WORK_BITS;
        assign w_w = i_w[COMPONENT_BITS-1:SH];
        assign w_x = i_x[COMPONENT_BITS-1:SH];
        assign w_y = i_y[COMPONENT_BITS-1:SH];
        assign w_z = i_z[COMPONENT_BITS-1:SH];
    end else begin : g_ext
        assign w_w = WORK_BITS'(i_w);
        assign w_x = WORK_BITS'(i_x);
        assign w_y = WORK_BITS'(i_y);
        assign w_z = WORK_BITS'(i_z);
    end

    logic signed [PROD_W-1:0] r_p1_ww, r_p1_xx, r_p1_yy, r_p1_zz, r_p1_wx;
    logic signed [PROD_W-1:0] r_p1_yz, r_p1_wz, r_p1_xy, r_p1_wy, r_p1_zx;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_ww <= w_w * w_w;
            r_p1_xx <= w_x * w_x;
            r_p1_yy <= w_y * w_y;
            r_p1_zz <= w_z * w_z;
            r_p1_wx <= w_w * w_x;
            r_p1_yz <= w_y * w_z;
            r_p1_wz <= w_w * w_z;
            r_p1_xy <= w_x * w_y;
            r_p1_wy <= w_w * w_y;
            r_p1_zx <= w_z * w_x;
        end
    end

    logic signed [SUM_W-1:0] n_n2;
    logic signed [SUM_W-1:0] r_p2_n2, r_p2_p;

    assign n_n2 = SUM_W'(r_p1_ww) + SUM_W'(r_p1_xx) + SUM_W'(r_p1_yy) + SUM_W'(r_p1_zz);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2_n2  <= n_n2;
            o_roll_s <= (SUM_W'(r_p1_wx) + SUM_W'(r_p1_yz)) <<< 1;
            o_roll_c <= n_n2 - ((SUM_W'(r_p1_xx) + SUM_W'(r_p1_yy)) <<< 1);
            o_yaw_s  <= (SUM_W'(r_p1_wz) + SUM_W'(r_p1_xy)) <<< 1;
            o_yaw_c  <= n_n2 - ((SUM_W'(r_p1_yy) + SUM_W'(r_p1_zz)) <<< 1);
            r_p2_p   <= (SUM_W'(r_p1_wy) - SUM_W'(r_p1_zx)) <<< 1;
        end
    end

    // Fewest right shifts that bring q below 2^32.
    logic [T_W-1:0] n_t;
    always_comb begin
        n_t = '0;
        for (int i = PQ_W; i < SUM_W - 1; i++) begin
            if (r_p2_n2[i]) begin
                n_t = T_W'(i - PQ_W + 1);
            end
        end
    end

    logic signed [SUM_W-1:0] r_p3_n2, r_p3_p;
    logic [T_W-1:0]          r_p3_t;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p3_n2 <= r_p2_n2;
            r_p3_p  <= r_p2_p;
            r_p3_t  <= n_t;
        end
    end

    logic [PQ_W-1:0]         w_qs;
    logic signed [SUM_W-1:0] w_qe, w_ps, n_pc;

    assign w_qs = PQ_W'(r_p3_n2 >> r_p3_t);
    assign w_qe = $signed(SUM_W'(w_qs));
    assign w_ps = r_p3_p >>> r_p3_t;

    always_comb begin
        n_pc = w_ps;
        if (w_ps > w_qe) begin
            n_pc = w_qe;
        end else if (w_ps < -w_qe) begin
            n_pc = -w_qe;
        end
    end

    logic [PQ_W-1:0]        r_p4_q;
    logic signed [PP_W-1:0] r_p4_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p4_q <= w_qs;
            r_p4_p <= PP_W'(n_pc);
        end
    end

    logic [PQ_W-1:0]        n_pm;
    logic [RAD_W-1:0]       r_p5_qq, r_p5_pp;
    logic signed [PP_W-1:0] r_p5_p;

    assign n_pm = PQ_W'(r_p4_p[PP_W-1] ? -r_p4_p : r_p4_p);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p5_qq <= RAD_W'(r_p4_q) * RAD_W'(r_p4_q);
            r_p5_pp <= RAD_W'(n_pm) * RAD_W'(n_pm);
            r_p5_p  <= r_p4_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_v <= r_p5_qq - r_p5_pp;
            o_p <= r_p5_p;
        end
    end

endmodule

`default_nettype wire

// ===== sv/qte_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with p carried alongside.
// Depends on qte_pkg.
`default_nettype none

module qte_isqrt
    import qte_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [RAD_W-1:0]       i_v,
    input  wire logic signed [PP_W-1:0] i_p,
    output logic [PQ_W-1:0]             o_c,
    output logic signed [PP_W-1:0]      o_p
);

    logic [RAD_W-1:0]       r_v   [SQ_STAGES];
    logic [RAD_W-1:0]       r_res [SQ_STAGES];
    logic signed [PP_W-1:0] r_sd  [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
        logic [RAD_W-1:0]       w_v, w_res, w_sum;
        logic signed [PP_W-1:0] w_sd;

        if (k == 0) begin : g_first
            assign w_v   = i_v;
            assign w_res = '0;
            assign w_sd  = i_p;
        end else begin : g_next
            assign w_v   = r_v[k-1];
            assign w_res = r_res[k-1];
            assign w_sd  = r_sd[k-1];
        end

        assign w_sum = w_res + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_v >= w_sum) begin
                    r_v[k]   <= w_v - w_sum;
                    r_res[k] <= (w_res >> 1) + BIT;
                end else begin
                    r_v[k]   <= w_v;
                    r_res[k] <= w_res >> 1;
                end
                r_sd[k] <= w_sd;
            end
        end
    end

    assign o_c = r_res[SQ_STAGES-1][PQ_W-1:0];
    assign o_p = r_sd[SQ_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/qte_cordic.sv =====
// One atan2 lane: axis cases, normalization, half-turn fold and 31 vectoring CORDIC stages.
// Depends on qte_pkg.
`default_nettype none

module qte_cordic
    import qte_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [SUM_W-1:0] i_ya,
    input  wire logic signed [SUM_W-1:0] i_xb,
    output logic [ACC_W-1:0]             o_z
);

    logic [MAG_W-1:0] w_ma, w_mb;
    logic             n_sp;
    logic [ACC_W-1:0] n_zsp;

    assign w_ma = MAG_W'(i_ya < 0 ? -i_ya : i_ya);
    assign w_mb = MAG_W'(i_xb < 0 ? -i_xb : i_xb);
    assign n_sp = (i_xb == '0) || (i_ya == '0);

    // Operands on an axis have an exact angle and bypass the rotations.
    always_comb begin
        n_zsp = ANG_ZERO;
        if (i_xb == '0) begin
            if (i_ya > 0) begin
                n_zsp = ANG_HALF_PI;
            end else if (i_ya < 0) begin
                n_zsp = ANG_NHALF_PI;
            end
        end else if (i_xb < 0) begin
            n_zsp = ANG_PI;
        end
    end

    logic                    r_sp  [CORDIC_LAT];
    logic [ACC_W-1:0]        r_zsp [CORDIC_LAT];
    logic signed [NORM_W-1:0] r_ya [NORM_STEPS+1];
    logic signed [NORM_W-1:0] r_xb [NORM_STEPS+1];
    logic [MAG_W-1:0]         r_m  [NORM_STEPS+1];
    logic signed [CRD_W-1:0]  r_cy [CRD_STAGES+1];
    logic signed [CRD_W-1:0]  r_cx [CRD_STAGES+1];
    logic [ACC_W-1:0]         r_cz [CRD_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sp[0]  <= n_sp;
            r_zsp[0] <= n_zsp;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_sp[k]  <= r_sp[k-1];
                r_zsp[k] <= r_zsp[k-1];
            end
            r_ya[0] <= NORM_W'(i_ya);
            r_xb[0] <= NORM_W'(i_xb);
            r_m[0]  <= (w_ma > w_mb) ? w_ma : w_mb;
        end
    end

    // Binary-search doubling until the larger magnitude reaches 2^49.
    for (genvar j = 1; j <= NORM_STEPS; j++) begin : g_norm
        localparam int K = 1 << (NORM_STEPS - j);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_m[j-1][MAG_W-1 -: K] == '0) begin
                    r_ya[j] <= r_ya[j-1] <<< K;
                    r_xb[j] <= r_xb[j-1] <<< K;
                    r_m[j]  <= r_m[j-1] << K;
                end else begin
                    r_ya[j] <= r_ya[j-1];
                    r_xb[j] <= r_xb[j-1];
                    r_m[j]  <= r_m[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_xb[NORM_STEPS] < 0) begin
                r_cx[0] <= -CRD_W'(r_xb[NORM_STEPS]);
                r_cy[0] <= -CRD_W'(r_ya[NORM_STEPS]);
                r_cz[0] <= ANG_PI;
            end else begin
                r_cx[0] <= CRD_W'(r_xb[NORM_STEPS]);
                r_cy[0] <= CRD_W'(r_ya[NORM_STEPS]);
                r_cz[0] <= ANG_ZERO;
            end
        end
    end

    for (genvar i = 1; i <= CRD_STAGES; i++) begin : g_rot
        localparam logic [ACC_W-1:0] ATAN = f_atan(i - 1);
        logic signed [CRD_W-1:0] w_dx, w_dy;
        assign w_dx = r_cy[i-1] >>> (i - 1);
        assign w_dy = r_cx[i-1] >>> (i - 1);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_cy[i-1] > 0) begin
                    r_cx[i] <= r_cx[i-1] + w_dx;
                    r_cy[i] <= r_cy[i-1] - w_dy;
                    r_cz[i] <= r_cz[i-1] + ATAN;
                end else begin
                    r_cx[i] <= r_cx[i-1] - w_dx;
                    r_cy[i] <= r_cy[i-1] + w_dy;
                    r_cz[i] <= r_cz[i-1] - ATAN;
                end
            end
        end
    end

    assign o_z = r_sp[CORDIC_LAT-1] ? r_zsp[CORDIC_LAT-1] : r_cz[CRD_STAGES];

endmodule

`default_nettype wire

// ===== sv/quaternion_to_euler_angles_core.sv =====
// Top level of the quaternion to ZYX Euler angle core: front end, square root, three atan2 lanes.
// Depends on qte_pkg, qte_if, qte_prep, qte_isqrt and qte_cordic.
//
//   Channel   Direction  Handshake      Payload
//   i_quat    in         valid/ready    quat_w, quat_x, quat_y, quat_z
//   o_euler   out        valid/ready    roll_angle, pitch_angle, yaw_angle
//
// One quaternion is taken per cycle while the skid register is empty and reset is released.
// The first front-end register loads at the transfer edge itself, then follow the rest of the
// 6 front-end stages, 32 square-root stages, 39 atan2 stages, one rounding stage and the
// output register.
// Roll and yaw finish early and wait in a delay line until the pitch lane catches up.
// Reset (synchronous, active low) clears the pipeline, output and skid valid bits, not their data.
// When the output stalls, a finished result lands in a skid register and the pipeline
// then holds; the input is ready whenever the skid register is empty and reset is released.
`default_nettype none

module quaternion_to_euler_angles_core
    import qte_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
    parameter int ANGLE_BITS     = ANGLE_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    qte_quat_if.sink     i_quat,
    qte_euler_if.source  o_euler
);

    localparam int TOT    = PREP_LAT + SQ_STAGES + CORDIC_LAT + 1;
    localparam int RY_DLY = TOT - RY_LAT - CORDIC_LAT;
    // Half an output step of the 32-bit accumulator; zero when no bits are dropped.
    localparam logic [ACC_W-1:0] RND = ACC_W'(64'h8000_0000 >> ANGLE_BITS);

    function automatic logic [ANGLE_BITS-1:0] f_round(input logic [ACC_W-1:0] z);
        logic [ACC_W-1:0] r;
        r = z + RND;
        return r[ACC_W-1 -: ANGLE_BITS];
    endfunction

    // The whole pipeline advances together; it only holds while the skid register is full.
    logic w_en, w_acc;
    logic r_skid_vld, r_out_vld;
    logic [TOT-1:0] r_vld;

    assign w_en         = !r_skid_vld;
    // No transfer is taken while reset is asserted, since it would be dropped.
    assign i_quat.ready = w_en && i_rst_n;
    assign w_acc        = i_quat.valid && i_quat.ready;

    logic signed [SUM_W-1:0] w_roll_s, w_roll_c, w_yaw_s, w_yaw_c;
    logic [RAD_W-1:0]        w_v;
    logic signed [PP_W-1:0]  w_p, w_pd;
    logic [PQ_W-1:0]         w_c;
    logic signed [SUM_W-1:0] w_pya, w_pxb;
    logic [ACC_W-1:0]        w_roll_z, w_pitch_z, w_yaw_z;

    qte_prep #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_prep (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_w      (i_quat.quat_w),
        .i_x      (i_quat.quat_x),
        .i_y      (i_quat.quat_y),
        .i_z      (i_quat.quat_z),
        .o_roll_s (w_roll_s),
        .o_roll_c (w_roll_c),
        .o_yaw_s  (w_yaw_s),
        .o_yaw_c  (w_yaw_c),
        .o_v      (w_v),
        .o_p      (w_p)
    );

    qte_isqrt u_isqrt (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   (w_v),
        .i_p   (w_p),
        .o_c   (w_c),
        .o_p   (w_pd)
    );

    // Pitch is atan2(p, sqrt(q^2 - p^2)) on the scaled-down operands.
    assign w_pya = SUM_W'(w_pd);
    assign w_pxb = $signed(SUM_W'(w_c));

    qte_cordic u_roll (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ya  (w_roll_s),
        .i_xb  (w_roll_c),
        .o_z   (w_roll_z)
    );

    qte_cordic u_yaw (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ya  (w_yaw_s),
        .i_xb  (w_yaw_c),
        .o_z   (w_yaw_z)
    );

    qte_cordic u_pitch (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ya  (w_pya),
        .i_xb  (w_pxb),
        .o_z   (w_pitch_z)
    );

    logic [ANGLE_BITS-1:0] r_dly_roll [RY_DLY];
    logic [ANGLE_BITS-1:0] r_dly_yaw  [RY_DLY];
    logic [ANGLE_BITS-1:0] r_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOT-2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly_roll[0] <= f_round(w_roll_z);
            r_dly_yaw[0]  <= f_round(w_yaw_z);
            for (int k = 1; k < RY_DLY; k++) begin
                r_dly_roll[k] <= r_dly_roll[k-1];
                r_dly_yaw[k]  <= r_dly_yaw[k-1];
            end
            r_pitch <= f_round(w_pitch_z);
        end
    end

    // Output register with a skid register behind it.
    logic w_take, w_free, w_last;
    logic [ANGLE_BITS-1:0] r_out_roll, r_out_pitch, r_out_yaw;
    logic [ANGLE_BITS-1:0] r_skid_roll, r_skid_pitch, r_skid_yaw;

    assign w_take = r_out_vld && o_euler.ready;
    assign w_free = !r_out_vld || o_euler.ready;
    assign w_last = r_vld[TOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_free) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (w_last) begin
            if (w_free) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_free) begin
                r_out_roll  <= r_skid_roll;
                r_out_pitch <= r_skid_pitch;
                r_out_yaw   <= r_skid_yaw;
            end
        end else if (w_last) begin
            if (w_free) begin
                r_out_roll  <= r_dly_roll[RY_DLY-1];
                r_out_pitch <= r_pitch;
                r_out_yaw   <= r_dly_yaw[RY_DLY-1];
            end else begin
                r_skid_roll  <= r_dly_roll[RY_DLY-1];
                r_skid_pitch <= r_pitch;
                r_skid_yaw   <= r_dly_yaw[RY_DLY-1];
            end
        end
    end

    assign o_euler.valid       = r_out_vld;
    assign o_euler.roll_angle  = r_out_roll;
    assign o_euler.pitch_angle = r_out_pitch;
    assign o_euler.yaw_angle   = r_out_yaw;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register holds a result while the output register is empty");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |=> (r_vld == $past(r_vld)))
        else $error("pipeline moved while the skid register was full");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !o_euler.ready))
        else $error("skid register filled while the output was free");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_quat.valid && i_quat.ready) |=> r_vld[0])
        else $error("accepted transfer did not enter the pipeline");
`endif

endmodule

`default_nettype wire
